// ===== hdl/pid_controller_antiwindup_defines.svh =====
// assertion macros for the pid controller with conditional integration
// used by the top level only; no other dependencies
`ifndef PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PIDAW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pidaw same-cycle check failed");

// next-cycle implication, disabled during reset
`define PIDAW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidaw next-cycle check failed");

`endif

// ===== hdl/pidaw_pkg.sv =====
// shared types and constants for the pid controller with anti-windup
// no dependencies
package pidaw_pkg;

  localparam int DATA_W    = 16;
  localparam int ACC_W     = 32;
  localparam int PROD_W    = DATA_W + ACC_W;
  localparam int TERM_W    = 24;
  localparam int SUM_W     = 34;
  localparam int WIDE_W    = 32;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_GAIN_P   = 3'd1,
    CFG_GAIN_I   = 3'd2,
    CFG_GAIN_D   = 3'd3,
    CFG_OUT_MIN  = 3'd4,
    CFG_OUT_MAX  = 3'd5,
    CFG_MAX_STEP = 3'd6
  } cfg_idx_t;

  // mode codes
  localparam logic [1:0] MODE_PD  = 2'd0;
  localparam logic [1:0] MODE_PI  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;

  // limit status codes
  localparam logic [1:0] LIM_NONE = 2'd0;
  localparam logic [1:0] LIM_MAX  = 2'd1;
  localparam logic [1:0] LIM_MIN  = 2'd2;

  // operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_D = 2'd1,
    MUL_I = 2'd2,
    MUL_E = 2'd3
  } mul_sel_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     cap_p;
    logic     cap_d;
    logic     cap_i;
    logic     upd_acc;
    logic     load_out;
  } cmd_t;

endpackage

// ===== hdl/pidaw_in_if.sv =====
// input sample channel: valid/ready handshake and sample fields
// depends on pidaw_pkg
interface pidaw_in_if;
  import pidaw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] err_in;
  logic signed [DATA_W-1:0] rate_in;
  logic        [DATA_W-1:0] step_time;

  modport source(output valid, output err_in, output rate_in, output step_time,
                 input ready);
  modport sink(input valid, input err_in, input rate_in, input step_time,
               output ready);
endinterface

// ===== hdl/pidaw_out_if.sv =====
// result channel: valid/ready handshake and result fields
// depends on pidaw_pkg
interface pidaw_out_if;
  import pidaw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive_out;
  logic signed [WIDE_W-1:0] drive_raw;
  logic        [1:0]        limit_status;
  logic                     integrated;
  logic signed [WIDE_W-1:0] term_p;
  logic signed [WIDE_W-1:0] term_i;
  logic signed [WIDE_W-1:0] term_d;

  modport source(output valid, output drive_out, output drive_raw,
                 output limit_status, output integrated, output term_p,
                 output term_i, output term_d, input ready);
  modport sink(input valid, input drive_out, input drive_raw,
               input limit_status, input integrated, input term_p,
               input term_i, input term_d, output ready);
endinterface

// ===== hdl/pidaw_ctrl.sv =====
// sequencer for the pid controller: walks one sample through the datapath
// depends on pidaw_pkg
module pidaw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pidaw_pkg::cmd_t  cmd
);
  import pidaw_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL_P = 8'b0000_0010,
    ST_MUL_D = 8'b0000_0100,
    ST_MUL_I = 8'b0000_1000,
    ST_MUL_E = 8'b0001_0000,
    ST_UPD   = 8'b0010_0000,
    ST_MUL_J = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_sel  = MUL_P;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_sel = MUL_P;
        state_next  = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_sel = MUL_D;
        cmd.cap_p   = 1'b1;
        state_next  = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_sel = MUL_I;
        cmd.cap_d   = 1'b1;
        state_next  = ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd.mul_sel = MUL_E;
        cmd.cap_i   = 1'b1;
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        cmd.mul_sel = MUL_E;
        cmd.upd_acc = 1'b1;
        state_next  = ST_MUL_J;
      end
      ST_MUL_J: begin
        cmd.mul_sel = MUL_I;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // hold the integral product until the output register has room
        cmd.mul_sel = MUL_I;
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.load_out | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/pidaw_dp.sv =====
// datapath for the pid controller: config registers, shared multiplier,
// integral accumulator and result register; depends on pidaw_pkg
module pidaw_dp (
  input  logic                                         clk,
  input  logic                                         rst,
  input  pidaw_pkg::cmd_t                              cmd,
  input  logic                                         cfg_we,
  input  logic        [pidaw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic        [pidaw_pkg::DATA_W-1:0]          cfg_data,
  input  logic signed [pidaw_pkg::DATA_W-1:0]          err_in,
  input  logic signed [pidaw_pkg::DATA_W-1:0]          rate_in,
  input  logic        [pidaw_pkg::DATA_W-1:0]          step_time,
  output logic signed [pidaw_pkg::DATA_W-1:0]          drive_out,
  output logic signed [pidaw_pkg::WIDE_W-1:0]          drive_raw,
  output logic        [1:0]                            limit_status,
  output logic                                         integrated,
  output logic signed [pidaw_pkg::WIDE_W-1:0]          term_p,
  output logic signed [pidaw_pkg::WIDE_W-1:0]          term_i,
  output logic signed [pidaw_pkg::WIDE_W-1:0]          term_d
);
  import pidaw_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_HI  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] WIDE_HI = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_LO = {1'b1, {(WIDE_W-1){1'b0}}};

  // configuration
  logic        [1:0]        mode;
  logic signed [DATA_W-1:0] gain_p, gain_i, gain_d, out_min, out_max;
  logic        [DATA_W-1:0] max_step;

  // working registers
  logic signed [DATA_W-1:0] err_q, rate_q;
  logic        [DATA_W-1:0] dt_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] tp, td;
  logic signed [ACC_W-1:0]  ti;
  logic                     did;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [ACC_W-1:0]  mul_b;
  logic                     mode_pd, mode_pi;
  logic signed [SUM_W-1:0]  lo_w, hi_w, pre, raw;
  logic signed [ACC_W-1:0]  ti_new;
  logic signed [TERM_W-1:0] inc;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;
  logic                     in_window, red_hi, red_lo, int_ok;
  logic signed [WIDE_W-1:0] raw_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PID;
      gain_p   <= '0;
      gain_i   <= '0;
      gain_d   <= '0;
      out_min  <= {1'b1, {(DATA_W-1){1'b0}}};
      out_max  <= {1'b0, {(DATA_W-1){1'b1}}};
      max_step <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:     mode     <= cfg_data[1:0];
        CFG_GAIN_P:   gain_p   <= cfg_data;
        CFG_GAIN_I:   gain_i   <= cfg_data;
        CFG_GAIN_D:   gain_d   <= cfg_data;
        CFG_OUT_MIN:  out_min  <= cfg_data;
        CFG_OUT_MAX:  out_max  <= cfg_data;
        CFG_MAX_STEP: max_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mode_pd = (mode == MODE_PD);
  assign mode_pi = (mode == MODE_PI);

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = gain_p;
        mul_b = ACC_W'(err_q);
      end
      MUL_D: begin
        mul_a = gain_d;
        mul_b = ACC_W'(rate_q);
      end
      MUL_I: begin
        mul_a = gain_i;
        mul_b = acc;
      end
      MUL_E: begin
        mul_a = err_q;
        mul_b = {{(ACC_W-DATA_W){1'b0}}, dt_q};
      end
      default: begin
        mul_a = gain_p;
        mul_b = ACC_W'(err_q);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // pre-update sum and integration condition
  assign lo_w      = SUM_W'(out_min);
  assign hi_w      = SUM_W'(out_max);
  assign pre       = SUM_W'(tp) + SUM_W'(ti) - SUM_W'(td);
  assign in_window = (pre >= lo_w) && (pre < hi_w);
  assign red_hi    = (pre > hi_w) && err_q[DATA_W-1];
  assign red_lo    = (pre < lo_w) && !err_q[DATA_W-1] && (err_q != '0);
  assign int_ok    = !mode_pd && (gain_i != '0) && (dt_q != '0) && (dt_q < max_step)
                     && (in_window || red_hi || red_lo);

  // err*dt stays within 32 signed bits, floor shift by 8
  assign inc     = prod[TERM_W+7:8];
  assign acc_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(inc);
  always_comb begin
    if (acc_sum > (ACC_W+1)'(ACC_HI)) begin
      acc_sat = ACC_HI;
    end else if (acc_sum < (ACC_W+1)'(ACC_LO)) begin
      acc_sat = ACC_LO;
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // final sum with the updated integral term
  assign ti_new = mode_pd ? '0 : prod[PROD_W-1:16];
  assign raw    = SUM_W'(tp) + SUM_W'(ti_new) - SUM_W'(td);

  always_comb begin
    if (raw > SUM_W'(WIDE_HI)) begin
      raw_sat = WIDE_HI;
    end else if (raw < SUM_W'(WIDE_LO)) begin
      raw_sat = WIDE_LO;
    end else begin
      raw_sat = raw[WIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.upd_acc && int_ok) begin
      acc <= acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_q  <= err_in;
      rate_q <= rate_in;
      dt_q   <= step_time;
    end
    if (cmd.cap_p) begin
      tp <= prod[TERM_W+7:8];
    end
    if (cmd.cap_d) begin
      td <= mode_pi ? '0 : prod[TERM_W+7:8];
    end
    if (cmd.cap_i) begin
      ti <= mode_pd ? '0 : prod[PROD_W-1:16];
    end
    if (cmd.upd_acc) begin
      did <= int_ok;
    end
    if (cmd.load_out) begin
      if (raw >= hi_w) begin
        drive_out    <= out_max;
        limit_status <= LIM_MAX;
      end else if (raw <= lo_w) begin
        drive_out    <= out_min;
        limit_status <= LIM_MIN;
      end else begin
        drive_out    <= raw[DATA_W-1:0];
        limit_status <= LIM_NONE;
      end
      drive_raw  <= raw_sat;
      integrated <= did;
      term_p     <= WIDE_W'(tp);
      term_i     <= ti_new;
      term_d     <= WIDE_W'(td);
    end
  end

endmodule

// ===== hdl/pid_controller_antiwindup.sv =====
// top level of the pid controller with conditional-integration anti-windup
// depends on pidaw_pkg, pidaw_in_if, pidaw_out_if, pidaw_ctrl, pidaw_dp
//
//  channel   | dir | handshake          | content
//  ----------+-----+--------------------+------------------------------------------
//  sample    | in  | valid/ready        | err_in, rate_in, step_time
//  result    | out | valid/ready        | drive_out, drive_raw, status, terms
//  cfg       | in  | cfg_we, no ready   | cfg_index selects register, cfg_data
//
// a new sample is accepted only once the previous one has loaded its result; five
// products (p, d, old integral, err*dt, new integral) share one 16x32 multiplier
// with a register behind it, one state updates the integral and one, which waits
// for room in the result register, loads the clamped result
// synchronous active-high reset restores the register defaults and a zero integral
// a held result does not block the next sample; only the final load waits for room
`include "pid_controller_antiwindup_defines.svh"

module pid_controller_antiwindup (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidaw_pkg::DATA_W-1:0]         cfg_data,
  pidaw_in_if.sink                             sample,
  pidaw_out_if.source                          result
);
  import pidaw_pkg::*;

  cmd_t cmd;

  // sequencer: handshake on both channels and step commands
  pidaw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // datapath: config registers, multiplier, integral and result register
  pidaw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .err_in       (sample.err_in),
    .rate_in      (sample.rate_in),
    .step_time    (sample.step_time),
    .drive_out    (result.drive_out),
    .drive_raw    (result.drive_raw),
    .limit_status (result.limit_status),
    .integrated   (result.integrated),
    .term_p       (result.term_p),
    .term_i       (result.term_i),
    .term_d       (result.term_d)
  );

  // an accepted item keeps the input closed while it is worked on
  `PIDAW_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample.valid && sample.ready, !sample.ready)

  // capture and update strobes never overlap
  `PIDAW_ASSERT_NOW(a_strobes_excl, clk, rst, 1'b1,
    $onehot0({cmd.cap_p, cmd.cap_d, cmd.cap_i, cmd.upd_acc, cmd.load_out}))

  // a loaded result is presented in the next cycle
  `PIDAW_ASSERT_NEXT(a_load_shows, clk, rst, cmd.load_out, result.valid)

  // the result register is only loaded while no sample is being taken
  `PIDAW_ASSERT_NOW(a_load_not_idle, clk, rst, cmd.load_out, !sample.ready)

endmodule

// ===== dv/pidaw_checker.sv =====
// result checker for the pid controller: follows register writes, predicts every result
// depends on pidaw_pkg, pidaw_in_if and pidaw_out_if
module pidaw_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pidaw_pkg::DATA_W-1:0]    cfg_data,
  pidaw_in_if                             sample,
  pidaw_out_if                            result,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pidaw_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_out;
    logic signed [WIDE_W-1:0] drive_raw;
    logic [1:0]               limit_status;
    logic                     integrated;
    logic signed [WIDE_W-1:0] term_p;
    logic signed [WIDE_W-1:0] term_i;
    logic signed [WIDE_W-1:0] term_d;
  } drive_result_t;

  logic [1:0]               mode_q;
  logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, lo_q, hi_q;
  logic [DATA_W-1:0]        step_cap_q;
  longint                   integ_acc;
  drive_result_t            expected_drive[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint clip(input longint x, input int w);
    longint top, bottom;
    top    = (longint'(1) <<< (w - 1)) - 1;
    bottom = -top - 1;
    if (x > top) return top;
    if (x < bottom) return bottom;
    return x;
  endfunction

  // one control update, integral state advanced in place
  function automatic drive_result_t predict_drive(input logic signed [DATA_W-1:0] err,
                                                  input logic signed [DATA_W-1:0] rate,
                                                  input logic [DATA_W-1:0] dt);
    longint        e, dt_w, tp, ti, td, pre, raw;
    logic          pd_mode, pi_mode, can_wind, did;
    drive_result_t r;
    e       = err;
    dt_w    = dt;
    pd_mode = (mode_q == MODE_PD);
    pi_mode = (mode_q == MODE_PI);
    did     = 1'b0;
    tp = (longint'(kp_q) * e) >>> 8;
    td = pi_mode ? longint'(0) : ((longint'(kd_q) * longint'(rate)) >>> 8);
    ti = 0;
    if (!pd_mode) begin
      ti  = (longint'(ki_q) * integ_acc) >>> 16;
      pre = tp + ti - td;
      can_wind = (pre >= lo_q && pre < hi_q) || (pre > hi_q && e < 0) ||
                 (pre < lo_q && e > 0);
      if (ki_q != 0 && dt != 0 && dt < step_cap_q && can_wind) begin
        integ_acc = clip(integ_acc + ((e * dt_w) >>> 8), ACC_W);
        did = 1'b1;
      end
      ti = (longint'(ki_q) * integ_acc) >>> 16;
    end
    raw = tp + ti - td;
    if (raw >= hi_q) begin
      r.drive_out    = hi_q;
      r.limit_status = LIM_MAX;
    end else if (raw <= lo_q) begin
      r.drive_out    = lo_q;
      r.limit_status = LIM_MIN;
    end else begin
      r.drive_out    = raw[DATA_W-1:0];
      r.limit_status = LIM_NONE;
    end
    r.drive_raw  = WIDE_W'(clip(raw, WIDE_W));
    r.integrated = did;
    r.term_p     = WIDE_W'(clip(tp, WIDE_W));
    r.term_i     = WIDE_W'(clip(ti, WIDE_W));
    r.term_d     = WIDE_W'(clip(td, WIDE_W));
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      mode_q     = MODE_PID;
      kp_q       = '0;
      ki_q       = '0;
      kd_q       = '0;
      lo_q       = 16'sh8000;
      hi_q       = 16'sh7fff;
      step_cap_q = 16'hffff;
      integ_acc  = 0;
      expected_drive.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MODE:     mode_q     = cfg_data[1:0];
          CFG_GAIN_P:   kp_q       = cfg_data;
          CFG_GAIN_I:   ki_q       = cfg_data;
          CFG_GAIN_D:   kd_q       = cfg_data;
          CFG_OUT_MIN:  lo_q       = cfg_data;
          CFG_OUT_MAX:  hi_q       = cfg_data;
          CFG_MAX_STEP: step_cap_q = cfg_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_drive.size() == 0) begin
          $display("%0t: result item with nothing expected, got drive_out %0d", $time,
                   result.drive_out);
          fail_count++;
        end else begin
          want = expected_drive.pop_front();
          compare_field("drive_out", want.drive_out, result.drive_out);
          compare_field("drive_raw", want.drive_raw, result.drive_raw);
          compare_field("limit_status", want.limit_status, result.limit_status);
          compare_field("integrated", want.integrated, result.integrated);
          compare_field("term_p", want.term_p, result.term_p);
          compare_field("term_i", want.term_i, result.term_i);
          compare_field("term_d", want.term_d, result.term_d);
        end
      end
      if (sample.valid && sample.ready)
        expected_drive.push_back(predict_drive(sample.err_in, sample.rate_in,
                                               sample.step_time));
    end
    pending = expected_drive.size();
  end

endmodule

// ===== dv/pid_controller_antiwindup_test.sv =====
// top of the pid controller testbench: clock, reset, register writes, sample and
// result traffic, verdict; depends on pidaw_pkg, both channel interfaces and pidaw_checker
module pid_controller_antiwindup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pidaw_pkg::*;

  // the spare mode encoding, expected to act as full pid
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         RAND_PHASES = 8;
  localparam int         PHASE_ITEMS = 45;
  localparam int         WINDUP_ITEMS = 300;
  // latency of one sample plus some margin
  localparam int         DRAIN_CYCLES = 20;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  int                   cycle_count;

  // sender burst state and the receiver stall pattern
  int                   burst_left;
  bit                   steady_tx;
  int                   rx_left;
  int                   rx_mode;
  // copy of the time step limit, used to aim time steps at its edge
  logic [DATA_W-1:0]    step_cap;

  pidaw_in_if  sample_ch ();
  pidaw_out_if result_ch ();

  pid_controller_antiwindup uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  pidaw_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on the whole run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: a new stall pattern is drawn whenever the current one runs out
  initial begin
    rx_left = 0;
    rx_mode = 0;
  end
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      0: result_ch.ready <= 1'b1;                          // no stalls at all
      1: result_ch.ready <= ($urandom_range(0, 9) < 6);    // scattered stalls
      2: result_ch.ready <= ((rx_left % 4) != 0);          // periodic stall
      default: result_ch.ready <= ($urandom_range(0, 7) == 0); // mostly stalled
    endcase
  end

  // register write, one cycle wide, lowered at the following falling edge
  task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_MAX_STEP) step_cap = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one sample item; a new burst may start with a gap
  task automatic send_item(input logic [DATA_W-1:0] err, input logic [DATA_W-1:0] rate,
                           input logic [DATA_W-1:0] dt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_tx ? 0 :
            (($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3));
      if (gap > 0) begin
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    sample_ch.valid     <= 1'b1;
    sample_ch.err_in    <= err;
    sample_ch.rate_in   <= rate;
    sample_ch.step_time <= dt;
    do @(posedge clk); while (!sample_ch.ready);
    burst_left--;
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'($urandom_range(0, 16'h0800)) - 16'h0400;
      default: return 16'($urandom);
    endcase
  endfunction

  // gains mostly near unity so the loop stays inside its limits now and then
  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      3: return 16'($urandom_range(0, 16'h0010)) - 16'h0008;
      default: return 16'($urandom_range(0, 16'h0600)) - 16'h0300;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return step_cap;
      3: return step_cap - 16'h0001;
      4: return 16'($urandom_range(1, 16'h0200));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic randomize_settings();
    logic [DATA_W-1:0] a, b, lim_lo, lim_hi;
    write_reg(CFG_MODE, 16'($urandom_range(0, 3)));
    write_reg(CFG_GAIN_P, pick_gain());
    write_reg(CFG_GAIN_I, ($urandom_range(0, 4) == 0) ? 16'h0000 : pick_gain());
    write_reg(CFG_GAIN_D, pick_gain());
    a = pick_word();
    b = pick_word();
    case ($urandom_range(0, 5))
      0: begin
        // widest window
        lim_lo = 16'h8000;
        lim_hi = 16'h7fff;
      end
      1: begin
        // taken as drawn, often crossed
        lim_lo = a;
        lim_hi = b;
      end
      default: begin
        lim_lo = ($signed(a) > $signed(b)) ? b : a;
        lim_hi = ($signed(a) > $signed(b)) ? a : b;
      end
    endcase
    write_reg(CFG_OUT_MIN, lim_lo);
    write_reg(CFG_OUT_MAX, lim_hi);
    case ($urandom_range(0, 4))
      0: write_reg(CFG_MAX_STEP, 16'h0000);
      1: write_reg(CFG_MAX_STEP, 16'hffff);
      2: write_reg(CFG_MAX_STEP, 16'($urandom_range(1, 16'h0100)));
      default: write_reg(CFG_MAX_STEP, 16'($urandom));
    endcase
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.err_in    = '0;
    sample_ch.rate_in   = '0;
    sample_ch.step_time = '0;
    result_ch.ready     = 1'b0;
    burst_left          = 0;
    steady_tx           = 1'b0;
    step_cap            = 16'hffff;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults: pid mode with all gains zero
    send_item(16'h1234, 16'h4321, 16'h0100);
    drain();

    // unity p and i, half d, narrow window, step limit at one half
    write_reg(CFG_MODE, 16'(MODE_PID));
    write_reg(CFG_GAIN_P, 16'h0100);
    write_reg(CFG_GAIN_I, 16'h0100);
    write_reg(CFG_GAIN_D, 16'h0080);
    write_reg(CFG_OUT_MIN, 16'hf800);
    write_reg(CFG_OUT_MAX, 16'h0800);
    write_reg(CFG_MAX_STEP, 16'h8000);
    send_item(16'h0000, 16'h0000, 16'h0000);   // zero step, no integration
    send_item(16'h7fff, 16'h7fff, 16'h7fff);   // field maxima, step just below limit
    send_item(16'h8000, 16'h8000, 16'h7fff);   // field minima
    send_item(16'h0100, 16'h0000, 16'h8000);   // step equal to limit
    send_item(16'h0100, 16'h0000, 16'hffff);   // step above limit
    send_item(16'h0100, 16'h0000, 16'h0001);   // smallest step
    send_item(16'hffff, 16'hffff, 16'h0001);
    send_item(16'h7fff, 16'h0000, 16'h7fff);   // drive above max, positive error
    send_item(16'h8000, 16'h0000, 16'h7fff);   // negative error unwinds
    drain();

    // pd mode: output landing exactly on each limit
    write_reg(CFG_MODE, 16'(MODE_PD));
    write_reg(CFG_GAIN_D, 16'h0000);
    send_item(16'h0800, 16'h1234, 16'h0100);
    send_item(16'hf800, 16'h1234, 16'h0100);
    send_item(16'h7fff, 16'h8000, 16'hffff);
    drain();

    // pi mode: a large d gain must have no effect
    write_reg(CFG_MODE, 16'(MODE_PI));
    write_reg(CFG_GAIN_D, 16'h7fff);
    send_item(16'h0100, 16'h7fff, 16'h0064);
    send_item(16'hff00, 16'h8000, 16'h00c8);
    drain();

    // spare mode code behaves as full pid
    write_reg(CFG_MODE, 16'(MODE_SPARE));
    send_item(16'h0200, 16'h0100, 16'h012c);
    drain();

    // crossed limits: the max test wins
    write_reg(CFG_MODE, 16'(MODE_PID));
    write_reg(CFG_OUT_MIN, 16'h0100);
    write_reg(CFG_OUT_MAX, 16'hff00);
    send_item(16'h0000, 16'h0000, 16'h000a);
    send_item(16'h0080, 16'h0000, 16'h000a);
    send_item(16'h8000, 16'h7fff, 16'hfffe);
    drain();

    // random settings, random samples
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      randomize_settings();
      steady_tx = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(pick_word(), pick_word(), pick_step());
      drain();
    end

    // windup: smallest i gain keeps the sum inside the window, so the integral
    // keeps growing negative until it saturates at the accumulator bound
    write_reg(CFG_MODE, 16'(MODE_PID));
    write_reg(CFG_GAIN_P, 16'h0000);
    write_reg(CFG_GAIN_I, 16'h0001);
    write_reg(CFG_GAIN_D, 16'h0000);
    write_reg(CFG_OUT_MIN, 16'h8000);
    write_reg(CFG_OUT_MAX, 16'h7fff);
    write_reg(CFG_MAX_STEP, 16'hffff);
    steady_tx = 1'b0;
    for (int n = 0; n < WINDUP_ITEMS; n++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(pick_word(), pick_word(), pick_step());
      else
        send_item(16'h8000 + 16'($urandom_range(0, 3)), 16'($urandom), 16'hfffe);
    end
    drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pidaw_pkg.sv
hdl/pidaw_in_if.sv
hdl/pidaw_out_if.sv
hdl/pidaw_ctrl.sv
hdl/pidaw_dp.sv
hdl/pid_controller_antiwindup.sv
dv/pidaw_checker.sv
dv/pid_controller_antiwindup_test.sv
